/* rtl/hppa_pkg.sv */
// ----------------------------------------------------------------------------
// Homing pulse-position actuator package
// Shared widths, codes and request/result types for the actuator blocks.
// ----------------------------------------------------------------------------
package hppa_pkg;

  localparam int POSITION_BITS = 16;
  localparam int TIMER_BITS    = 16;
  localparam int TIMEOUT_BITS  = 16;
  localparam int FRAC_BITS     = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Width used to compare the timer count against the timeout setting.
  localparam int CMP_BITS = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;

  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET   = TIMEOUT_BITS'(500);
  localparam logic [FRAC_BITS-1:0]    HOME_FRAC_RESET = FRAC_BITS'(128);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [TIMER_BITS-1:0]    tmr_t;
  typedef logic [FRAC_BITS-1:0]     frac_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_PULSE = 2'd1,
    CMD_GOTO  = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DOWN  = 2'd1,
    PH_UP    = 2'd2,
    PH_READY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    DRV_OFF  = 2'd0,
    DRV_DOWN = 2'd1,
    DRV_UP   = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TIMEOUT   = 2'd0,
    REG_HOME_FRAC = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t  cmd;
    frac_t frac;
  } req_t;

  typedef struct packed {
    drive_t drive;
    pos_t   position;
    pos_t   travel_range;
    pos_t   goal;
    phase_t phase;
  } res_t;

endpackage

/* rtl/hppa_in_reg.sv */
// ----------------------------------------------------------------------------
// Input register
// Captures one request and holds it until the update logic consumes it.
// ----------------------------------------------------------------------------
module hppa_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [7:0]          goto_fraction,
  input  logic                can_load,
  output logic                held_valid,
  output hppa_pkg::req_t      held_req
);
  import hppa_pkg::*;

  logic  advance;

  // The held request moves on whenever the result register can take a result.
  assign advance  = held_valid && can_load;
  assign in_ready = !held_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_req.cmd  <= cmd_t'(cmd);
      held_req.frac <= frac_t'(goto_fraction);
    end
  end

endmodule

/* rtl/hppa_core.sv */
// ----------------------------------------------------------------------------
// Actuator state and update logic
// Holds the homing, position and timer state and applies one request a cycle while go is high.
// ----------------------------------------------------------------------------
module hppa_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [hppa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hppa_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                           go,
  input  hppa_pkg::req_t                 req,
  output hppa_pkg::res_t                 res
);
  import hppa_pkg::*;

  logic [TIMEOUT_BITS-1:0] timeout_ticks;
  frac_t                   home_fraction;

  phase_t phase_reg,      phase_next;
  pos_t   position_reg,   position_next;
  pos_t   range_reg,      range_next;
  pos_t   goal_reg,       goal_next;
  dir_t   step_direction, step_direction_next;
  tmr_t   timer_count,    timer_count_next;
  logic   timer_armed,    timer_armed_next;
  drive_t drive_reg,      drive_next;

  tmr_t                         cnt_inc;
  logic                         fire;
  logic                         goto_req;
  frac_t                        mul_frac;
  pos_t                         mul_rng;
  logic [POSITION_BITS+FRAC_BITS-1:0] prod;
  pos_t                         goal_calc;
  pos_t                         pulse_pos;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      home_fraction <= HOME_FRAC_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT:   timeout_ticks <= cfg_data[TIMEOUT_BITS-1:0];
        REG_HOME_FRAC: home_fraction <= cfg_data[FRAC_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // The one multiplier serves both a goto request and the move home that
  // ends a homing run, where the freshly measured range is the position.
  assign mul_frac  = (req.cmd == CMD_GOTO) ? req.frac : home_fraction;
  assign mul_rng   = (req.cmd == CMD_GOTO) ? range_reg : position_reg;
  assign prod      = (POSITION_BITS+FRAC_BITS)'(mul_frac) *
                     (POSITION_BITS+FRAC_BITS)'(mul_rng);
  assign goal_calc = prod[POSITION_BITS+FRAC_BITS-1:FRAC_BITS];

  assign cnt_inc = (&timer_count) ? timer_count : timer_count + 1'b1;
  assign fire    = CMP_BITS'(cnt_inc) >= CMP_BITS'(timeout_ticks);

  always_comb begin
    phase_next          = phase_reg;
    position_next       = position_reg;
    range_next          = range_reg;
    goal_next           = goal_reg;
    step_direction_next = step_direction;
    timer_count_next    = timer_count;
    timer_armed_next    = timer_armed;
    drive_next          = drive_reg;
    goto_req            = 1'b0;
    pulse_pos           = position_reg;

    if (go) begin
      case (req.cmd)
        CMD_TICK: begin
          if (timer_armed) begin
            if (fire) begin
              step_direction_next = DIR_NONE;
              drive_next          = DRV_OFF;
              timer_armed_next    = 1'b0;
              timer_count_next    = '0;
              case (phase_reg)
                PH_DOWN: begin
                  position_next    = '0;
                  phase_next       = PH_UP;
                  timer_armed_next = 1'b1;
                  drive_next       = DRV_UP;
                end
                PH_UP: begin
                  range_next = position_reg;
                  phase_next = PH_READY;
                  goto_req   = 1'b1;
                end
                default: ;
              endcase
            end else begin
              timer_count_next = cnt_inc;
            end
          end
        end
        CMD_PULSE: begin
          if (phase_reg != PH_IDLE) begin
            timer_armed_next = 1'b1;
            timer_count_next = '0;
            if (phase_reg == PH_UP) begin
              if (!(&position_reg)) begin
                position_next = position_reg + 1'b1;
              end
            end else if (phase_reg == PH_READY) begin
              if (step_direction == DIR_UP && !(&position_reg)) begin
                pulse_pos = position_reg + 1'b1;
              end else if (step_direction == DIR_DOWN && position_reg != '0) begin
                pulse_pos = position_reg - 1'b1;
              end
              position_next = pulse_pos;
              if (pulse_pos == goal_reg) begin
                step_direction_next = DIR_NONE;
                drive_next          = DRV_OFF;
                timer_armed_next    = 1'b0;
              end
            end
          end
        end
        CMD_GOTO: begin
          goto_req = 1'b1;
        end
        CMD_START: begin
          step_direction_next = DIR_NONE;
          phase_next          = PH_DOWN;
          timer_armed_next    = 1'b1;
          timer_count_next    = '0;
          drive_next          = DRV_DOWN;
        end
        default: ;
      endcase

      // A goto takes effect only once homing has produced a nonzero range.
      if (goto_req && range_next != '0 && phase_next == PH_READY) begin
        goal_next           = goal_calc;
        step_direction_next = DIR_NONE;
        drive_next          = DRV_OFF;
        timer_armed_next    = 1'b0;
        timer_count_next    = '0;
        if (goal_calc > position_next) begin
          step_direction_next = DIR_UP;
          drive_next          = DRV_UP;
          timer_armed_next    = 1'b1;
        end else if (goal_calc < position_next) begin
          step_direction_next = DIR_DOWN;
          drive_next          = DRV_DOWN;
          timer_armed_next    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_IDLE;
      position_reg   <= '0;
      range_reg      <= '0;
      goal_reg       <= '0;
      step_direction <= DIR_NONE;
      timer_count    <= '0;
      timer_armed    <= 1'b0;
      drive_reg      <= DRV_OFF;
    end else begin
      phase_reg      <= phase_next;
      position_reg   <= position_next;
      range_reg      <= range_next;
      goal_reg       <= goal_next;
      step_direction <= step_direction_next;
      timer_count    <= timer_count_next;
      timer_armed    <= timer_armed_next;
      drive_reg      <= drive_next;
    end
  end

  assign res.drive        = drive_next;
  assign res.position     = position_next;
  assign res.travel_range = range_next;
  assign res.goal         = goal_next;
  assign res.phase        = phase_next;

  a_down_drive: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_DOWN |-> drive_reg == DRV_DOWN && step_direction == DIR_NONE)
    else $error("homing down without down drive");

  a_up_drive: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_UP |-> drive_reg == DRV_UP && timer_armed)
    else $error("homing up without up drive or timer");

  a_timer_clear: assert property (@(posedge clk) disable iff (rst)
    !timer_armed |-> timer_count == '0)
    else $error("disarmed timer holds a count");

  a_ready_dir: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_READY |->
      ((drive_reg == DRV_UP) == (step_direction == DIR_UP)) &&
      ((drive_reg == DRV_DOWN) == (step_direction == DIR_DOWN)))
    else $error("drive and count direction disagree");

  a_range_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(range_reg) |-> $past(phase_reg) == PH_UP && phase_reg == PH_READY)
    else $error("range changed outside the end of homing");

endmodule

/* rtl/hppa_out_reg.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module hppa_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  hppa_pkg::res_t res_in,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output hppa_pkg::res_t res_out
);
  import hppa_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

/* rtl/homing_pulse_position_actuator.sv */
// ----------------------------------------------------------------------------
// Homing pulse-position actuator
// Two-wire motor control with pulse counting, homing and goto positioning.
// ----------------------------------------------------------------------------
// Each input request carries cmd (timer tick, sensor pulse, goto, start
// homing) and goto_fraction. Every request produces exactly one result with
// the motor drive, counted position, travel range, goal and homing phase as
// they stand after that request.
// A request is first registered, then applied to the actuator state once
// the output register can take a result, and the result is captured there.
// One request per cycle is sustained while the receiver does not stall, the
// limit being the single update pass through the state registers (one 8 by
// 16 multiply and a compare for goto).
// The configuration channel is always ready; index 0 sets the timeout in
// ticks and index 1 the home fraction. Other indexes are ignored.
// Reset stops the motor, clears position, range and goal, and loads the
// default settings. When the receiver stalls, the result is held and the
// input register holds one more request, after which in_ready drops.
// ----------------------------------------------------------------------------
module homing_pulse_position_actuator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hppa_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hppa_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic [7:0]                         goto_fraction,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         drive,
  output hppa_pkg::pos_t                     position,
  output hppa_pkg::pos_t                     travel_range,
  output hppa_pkg::pos_t                     goal,
  output logic [1:0]                         phase
);
  import hppa_pkg::*;

  logic can_load;
  logic held_valid;
  logic go;
  req_t held_req;
  res_t res_next;
  res_t res_out;

  assign cfg_ready = 1'b1;
  assign go        = held_valid && can_load;

  hppa_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .goto_fraction (goto_fraction),
    .can_load      (can_load),
    .held_valid    (held_valid),
    .held_req      (held_req)
  );

  hppa_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .req       (held_req),
    .res       (res_next)
  );

  hppa_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (go),
    .res_in    (res_next),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign drive        = res_out.drive;
  assign position     = res_out.position;
  assign travel_range = res_out.travel_range;
  assign goal         = res_out.goal;
  assign phase        = res_out.phase;

endmodule
